// File: sv/b64e_pkg.sv
// ---------------------------------------------------------------------------
// b64e_pkg: shared types and constants of the base64 stream encoder
// Item job format, queue sizing, CSR indexes and the sextet-to-ASCII map.
// ---------------------------------------------------------------------------
`default_nettype none

package b64e_pkg;

   // CSR indexes
   localparam int unsigned CSR_ADDR_W = 1;
   localparam logic [CSR_ADDR_W-1:0] CSR_URL_ALPHABET = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PAD_ENABLE   = 1'd1;

   // job queue between front and back
   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QPTR_W = $clog2(QDEPTH);
   localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

   // characters per job: up to four
   localparam int unsigned JOB_ENTS = 4;
   localparam int unsigned JOB_IDX_W = $clog2(JOB_ENTS);

   // ASCII codes
   localparam logic [6:0] CH_UPPER_A = 7'h41;
   localparam logic [6:0] CH_LOWER_A = 7'h61;
   localparam logic [6:0] CH_DIGIT_0 = 7'h30;
   localparam logic [6:0] CH_PLUS    = 7'h2B;
   localparam logic [6:0] CH_SLASH   = 7'h2F;
   localparam logic [6:0] CH_MINUS   = 7'h2D;
   localparam logic [6:0] CH_UNDER   = 7'h5F;
   localparam logic [6:0] CH_PAD     = 7'h3D;

   // position of the next byte within its 3-byte group
   typedef enum logic [2:0] {
      PH_0 = 3'b001,
      PH_1 = 3'b010,
      PH_2 = 3'b100
   } phase_type;

   // one output character: a sextet or a pad
   typedef struct packed {
      logic       pad;
      logic [5:0] six;
   } entry_type;

   // the characters produced by one input item
   typedef struct packed {
      entry_type [JOB_ENTS-1:0] ent;
      logic [JOB_IDX_W-1:0]     last_idx;  // index of the job's final character
      logic                     last;      // job ends the message
   } job_type;

   // sextet to ASCII, standard or URL-safe alphabet
   function automatic logic [6:0] b64_char(input logic [5:0] six, input logic url);
      logic [6:0] v;
      v = {1'b0, six};
      if (six < 6'd26) begin
         return CH_UPPER_A + v;
      end else if (six < 6'd52) begin
         return CH_LOWER_A - 7'd26 + v;
      end else if (six < 6'd62) begin
         return CH_DIGIT_0 - 7'd52 + v;
      end else if (six == 6'd62) begin
         return url ? CH_MINUS : CH_PLUS;
      end else begin
         return url ? CH_UNDER : CH_SLASH;
      end
   endfunction

endpackage

`default_nettype wire

// File: sv/b64e_front.sv
// ---------------------------------------------------------------------------
// b64e_front: byte intake and group slicing
// Tracks the group phase and leftover bits, and turns each byte into a job
// of one to four sextet or pad characters.
// ---------------------------------------------------------------------------
`default_nettype none

module b64e_front
   import b64e_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       pad_enable,
   input  wire logic       in_valid,
   input  wire logic [7:0] in_byte,
   input  wire logic       in_final,
   output logic            in_ready,
   input  wire logic       q_full,
   output logic            q_push,
   output job_type         q_job
);

   phase_type  phase_ff, phase_in;
   logic [3:0] carry_ff, carry_in;
   logic       accept;

   assign in_ready = ~q_full;
   assign accept   = in_valid & in_ready;
   assign q_push   = accept;

   always_comb begin
      q_job    = '0;
      q_job.last = in_final;
      phase_in = phase_ff;
      carry_in = carry_ff;
      unique case (phase_ff)
         PH_1: begin
            q_job.ent[0].six = {carry_ff[1:0], in_byte[7:4]};
            q_job.last_idx   = 2'd0;
            carry_in         = in_byte[3:0];
            phase_in         = PH_2;
            if (in_final) begin
               q_job.ent[1].six = {in_byte[3:0], 2'b00};
               q_job.last_idx   = 2'd1;
               if (pad_enable) begin
                  q_job.ent[2].pad = 1'b1;
                  q_job.last_idx   = 2'd2;
               end
            end
         end
         PH_2: begin
            q_job.ent[0].six = {carry_ff, in_byte[7:6]};
            q_job.ent[1].six = in_byte[5:0];
            q_job.last_idx   = 2'd1;
            carry_in         = 4'd0;
            phase_in         = PH_0;
         end
         default: begin
            q_job.ent[0].six = in_byte[7:2];
            q_job.last_idx   = 2'd0;
            carry_in         = {2'b00, in_byte[1:0]};
            phase_in         = PH_1;
            if (in_final) begin
               q_job.ent[1].six = {in_byte[1:0], 4'b0000};
               q_job.last_idx   = 2'd1;
               if (pad_enable) begin
                  q_job.ent[2].pad = 1'b1;
                  q_job.ent[3].pad = 1'b1;
                  q_job.last_idx   = 2'd3;
               end
            end
         end
      endcase
      if (in_final) begin
         phase_in = PH_0;
         carry_in = 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_0;
         carry_ff <= 4'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         carry_ff <= carry_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_final_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && in_final |=> phase_ff == PH_0 && carry_ff == 4'd0)
      else $error("group state not cleared after final byte");

   a_phase2_no_pad: assert property (@(posedge clock) disable iff (reset)
      q_push && phase_ff == PH_2 |-> !q_job.ent[0].pad && !q_job.ent[1].pad)
      else $error("pad produced on a completed group");
`endif

endmodule

`default_nettype wire

// File: sv/b64e_queue.sv
// ---------------------------------------------------------------------------
// b64e_queue: job queue
// Small FIFO of jobs that lets intake and character output stall apart.
// ---------------------------------------------------------------------------
`default_nettype none

module b64e_queue
   import b64e_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  job_type   push_job,
   output logic      full,
   input  wire logic pop,
   output logic      empty,
   output job_type   head_job
);

   job_type             slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;

   assign full     = (cnt_ff == QCNT_W'(QDEPTH));
   assign empty    = (cnt_ff == '0);
   assign head_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef NO_ASSERTIONS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QDEPTH))
      else $error("queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// File: sv/b64e_back.sv
// ---------------------------------------------------------------------------
// b64e_back: character output
// Walks the head job one character per cycle into the output register, while the output is not stalled.
// ---------------------------------------------------------------------------
`default_nettype none

module b64e_back
   import b64e_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       url_alphabet,
   input  wire logic       q_empty,
   input  job_type         q_head,
   output logic            q_pop,
   output logic            out_valid,
   output logic [6:0]      out_char,
   output logic            out_last,
   input  wire logic       out_ready
);

   logic [JOB_IDX_W-1:0] idx_ff, idx_in;
   logic                 valid_ff, valid_in;
   logic [6:0]           char_ff;
   logic                 last_ff;
   logic                 load;
   logic                 end_of_job;
   entry_type            cur;
   logic [6:0]           cur_char;

   assign cur        = q_head.ent[idx_ff];
   assign cur_char   = cur.pad ? CH_PAD : b64_char(cur.six, url_alphabet);
   assign end_of_job = (idx_ff == q_head.last_idx);
   assign load       = ~q_empty & (~valid_ff | out_ready);
   assign q_pop      = load & end_of_job;
   assign valid_in   = load | (valid_ff & ~out_ready);
   assign idx_in     = load ? (end_of_job ? '0 : idx_ff + 1'b1) : idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= cur_char;
         last_ff <= q_head.last & end_of_job;
      end
   end

   assign out_valid = valid_ff;
   assign out_char  = char_ff;
   assign out_last  = last_ff;

`ifndef NO_ASSERTIONS
   a_idx_in_job: assert property (@(posedge clock) disable iff (reset)
      !q_empty |-> idx_ff <= q_head.last_idx)
      else $error("character index past end of job");

   a_idx_idle_zero: assert property (@(posedge clock) disable iff (reset)
      q_empty |-> idx_ff == '0)
      else $error("character index left mid-job with queue empty");
`endif

endmodule

`default_nettype wire

// File: sv/base64_stream_encoder.sv
// ---------------------------------------------------------------------------
// base64_stream_encoder: streaming base64 encoder
// Bytes in with a final flag, base64 / pad characters out with an end mark.
// ---------------------------------------------------------------------------
//
//  channel | direction | payload
//  --------+-----------+------------------------------------------------
//  req_    | in        | tdata[7:0] data_byte, tlast final_byte
//  rsp_    | out       | tdata[6:0] out_char (bit 7 zero), tlast out_last
//  csr_    | in        | addr 0 url_alphabet, addr 1 pad_enable; wdata[0]
//
//  A byte is taken whenever the job queue has room, also while earlier
//  characters are still out; it yields one to four characters, emitted one
//  per cycle by the back end while rsp_tready holds (output limited).
//  The first character reaches the output register through a job queue
//  slot, so its rsp_ handshake comes after both registers.
//  Reset is synchronous and active high; it empties the queue and restarts
//  the group. Output stalls fill the four-job queue before req_tready drops.
//
`default_nettype none

module base64_stream_encoder
   import b64e_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // input bytes
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [7:0]            req_tdata,   // [7:0] data_byte
   input  wire logic                  req_tlast,   // final_byte
   // output characters
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [7:0]                 rsp_tdata,   // [6:0] out_char, [7] zero
   output logic                       rsp_tlast,   // out_last
   // configuration
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic                  csr_wdata
);

   logic    url_ff;
   logic    pad_ff;

   logic    q_push;
   logic    q_pop;
   logic    q_full;
   logic    q_empty;
   job_type push_job;
   job_type head_job;
   logic [6:0] out_char;

   // configuration registers; write only while idle (the block does not enforce it)
   always_ff @(posedge clock) begin
      if (reset) begin
         url_ff <= 1'b0;
         pad_ff <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_URL_ALPHABET: url_ff <= csr_wdata;
            CSR_PAD_ENABLE:   pad_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // front: byte slicing into character jobs
   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .pad_enable (pad_ff),
      .in_valid   (req_tvalid),
      .in_byte    (req_tdata),
      .in_final   (req_tlast),
      .in_ready   (req_tready),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_job      (push_job)
   );

   // decoupling queue
   b64e_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head_job (head_job)
   );

   // back: one character per cycle into the output register while the output is not stalled
   b64e_back u_back (
      .clock        (clock),
      .reset        (reset),
      .url_alphabet (url_ff),
      .q_empty      (q_empty),
      .q_head       (head_job),
      .q_pop        (q_pop),
      .out_valid    (rsp_tvalid),
      .out_char     (out_char),
      .out_last     (rsp_tlast),
      .out_ready    (rsp_tready)
   );

   assign rsp_tdata = {1'b0, out_char};

`ifndef NO_ASSERTIONS
   a_char_ascii: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7] == 1'b0)
      else $error("output character outside ASCII range");
`endif

endmodule

`default_nettype wire

// File: tb/base64_stream_encoder_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// base64_stream_encoder_tb: self-checking testbench for the base64 encoder
// Feeds messages byte by byte with random gaps on both channels, predicts
// the character stream for each accepted byte, and checks every character
// and its end mark against the prediction.
// ---------------------------------------------------------------------------

module base64_stream_encoder_tb;
   import b64e_pkg::*;

   localparam int unsigned IDLE_LIMIT    = 2000;  // cycles with no handshake at all
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned MAX_GAP       = 18;
   localparam int unsigned PHASE_BYTES   = 70;    // random bytes per config setting
   localparam int unsigned SHOWN_FAILS   = 10;

   // alphabets, character 0 in the top byte
   localparam logic [8*64-1:0] STD_ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   localparam logic [8*64-1:0] URL_ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

   typedef struct packed {
      logic [6:0] code;
      logic       last;
   } enc_char_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;   // [7:0] data_byte
   logic                  req_tlast;   // final_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [7:0]            rsp_tdata;   // [6:0] out_char, [7] zero
   logic                  rsp_tlast;   // out_last
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic                  csr_wdata;

   // encoder mirror: config and group state
   logic       url_sel;
   logic       pad_on;
   phase_type  group_pos;
   logic [3:0] carry;

   enc_char_type encoded_chars[$];   // characters still owed by the block

   // idling switches, one per side
   logic req_idle;
   logic rsp_idle;

   int unsigned fail_count;
   int unsigned byte_count;
   int unsigned msg_count;
   int unsigned char_count;
   int unsigned csr_writes;
   int unsigned idle_cycles;

   base64_stream_encoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin : clock_gen
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // -----------------------------------------------------------------------
   // prediction
   // -----------------------------------------------------------------------

   function automatic logic [6:0] sextet_to_ascii(input logic [5:0] six);
      logic [8*64-1:0] alpha;
      alpha = url_sel ? URL_ALPHABET : STD_ALPHABET;
      return alpha[8*(63-six) +: 7];
   endfunction

   function automatic void owe_char(input logic [6:0] code);
      enc_char_type owed;
      owed.code = code;
      owed.last = 1'b0;
      encoded_chars.insert(encoded_chars.size(), owed);
   endfunction

   // one accepted byte: queue its characters and advance the group
   function automatic void encode_byte(input logic [7:0] b, input logic fin);
      case (group_pos)
         PH_1: begin
            owe_char(sextet_to_ascii({carry[1:0], b[7:4]}));
            carry = b[3:0];
            group_pos = PH_2;
            if (fin) begin
               // flush four leftover bits, one pad (if enabled) fills the group
               owe_char(sextet_to_ascii({carry, 2'b00}));
               if (pad_on) owe_char(CH_PAD);
            end
         end
         PH_2: begin
            owe_char(sextet_to_ascii({carry, b[7:6]}));
            owe_char(sextet_to_ascii(b[5:0]));
            carry = 4'd0;
            group_pos = PH_0;
         end
         default: begin
            owe_char(sextet_to_ascii(b[7:2]));
            carry = {2'b00, b[1:0]};
            group_pos = PH_1;
            if (fin) begin
               owe_char(sextet_to_ascii({carry[1:0], 4'b0000}));
               if (pad_on) begin
                  owe_char(CH_PAD);
                  owe_char(CH_PAD);
               end
            end
         end
      endcase
      if (fin) begin
         // end of message: mark the last character, next byte starts fresh
         encoded_chars[encoded_chars.size()-1].last = 1'b1;
         group_pos = PH_0;
         carry = 4'd0;
      end
   endfunction

   function automatic void note_failure(input string what);
      fail_count++;
      if (fail_count <= SHOWN_FAILS) $display("[%0t] ERROR: %s", $realtime, what);
   endfunction

   // -----------------------------------------------------------------------
   // result checker and watchdog, sampled at the rising edge
   // -----------------------------------------------------------------------
   always @(posedge clock) begin : char_check
      enc_char_type want;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end

         if (rsp_tvalid && rsp_tready) begin
            char_count++;
            if (encoded_chars.size() == 0) begin
               note_failure($sformatf("unexpected char tdata=0x%02h tlast=%0b",
                                      rsp_tdata, rsp_tlast));
            end else begin
               want = encoded_chars.pop_front();
               if (rsp_tdata !== {1'b0, want.code}) begin
                  note_failure($sformatf("char %0d: tdata exp 0x%02h got 0x%02h",
                                         char_count, {1'b0, want.code}, rsp_tdata));
               end
               if (rsp_tlast !== want.last) begin
                  note_failure($sformatf("char %0d: tlast exp %0b got %0b",
                                         char_count, want.last, rsp_tlast));
               end
            end
         end

         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[%0t] timeout: no handshake for %0d cycles, %0d chars owed",
                     $realtime, idle_cycles, encoded_chars.size());
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // -----------------------------------------------------------------------
   // output side: per-item random stall, driven at the falling edge
   // -----------------------------------------------------------------------
   initial begin : rsp_stall_gen
      int unsigned stall;
      rsp_tready = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         stall = rsp_idle ? $urandom_range(0, MAX_GAP) : 0;
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // -----------------------------------------------------------------------
   // shared tasks
   // -----------------------------------------------------------------------

   // one byte through the input channel; valid stays up when no gap follows
   task automatic send_byte(input logic [7:0] b, input logic fin);
      int unsigned gap;
      gap = req_idle ? $urandom_range(0, MAX_GAP) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      encode_byte(b, fin);
      byte_count++;
      if (fin) msg_count++;
   endtask

   task automatic send_random_msg(input int unsigned len);
      for (int unsigned i = 0; i < len; i++) begin
         send_byte(8'($urandom_range(0, 255)), i == len - 1);
      end
   endtask

   // drop valid and let every owed character drain out
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (encoded_chars.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // register write, only with the block idle
   task automatic write_csr(input logic [CSR_ADDR_W-1:0] addr, input logic value);
      wait_idle();
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (addr == CSR_URL_ALPHABET) url_sel = value;
      else pad_on = value;
      csr_writes++;
   endtask

   // -----------------------------------------------------------------------
   // tests
   // -----------------------------------------------------------------------

   // reset config (standard alphabet, padding on), back-to-back bytes,
   // messages ending at each group position, all-zero and all-one bytes
   task automatic test_default_encoding();
      req_idle = 1'b0;
      rsp_idle = 1'b0;
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h66, 1'b0);
      send_byte(8'h6F, 1'b0);
      send_byte(8'h6F, 1'b1);
      wait_idle();
   endtask

   // sextets 62 and 63 under both alphabets
   task automatic test_alphabet_select();
      req_idle = 1'b1;
      rsp_idle = 1'b1;
      send_byte(8'hFB, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hBF, 1'b1);
      write_csr(CSR_URL_ALPHABET, 1'b1);
      send_byte(8'hFB, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hBF, 1'b1);
      wait_idle();
   endtask

   // padding off: partial groups end on the data character itself
   task automatic test_pad_disable();
      write_csr(CSR_PAD_ENABLE, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'h7F, 1'b1);
      wait_idle();
   endtask

   // random messages under every config pair, with random idling mixes;
   // most messages short, a few long enough to cross many groups
   task automatic test_random_messages();
      int unsigned start_bytes;
      int unsigned len;
      for (int unsigned setting = 0; setting < 4; setting++) begin
         write_csr(CSR_URL_ALPHABET, setting[0]);
         write_csr(CSR_PAD_ENABLE, setting[1]);
         start_bytes = byte_count;
         while (byte_count - start_bytes < PHASE_BYTES) begin
            req_idle = ($urandom_range(0, 3) != 0);
            rsp_idle = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0) len = $urandom_range(13, 40);
            else len = $urandom_range(1, 6);
            send_random_msg(len);
            // now and then flip one register mid-phase
            if ($urandom_range(0, 7) == 0) begin
               if ($urandom_range(0, 1) == 0) begin
                  write_csr(CSR_URL_ALPHABET, 1'($urandom_range(0, 1)));
               end else begin
                  write_csr(CSR_PAD_ENABLE, 1'($urandom_range(0, 1)));
               end
            end
         end
      end
      wait_idle();
   endtask

   // -----------------------------------------------------------------------
   // main sequence
   // -----------------------------------------------------------------------
   initial begin : main_seq
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = 8'd0;
      req_tlast   = 1'b0;
      csr_we      = 1'b0;
      csr_addr    = CSR_URL_ALPHABET;
      csr_wdata   = 1'b0;
      req_idle    = 1'b0;
      rsp_idle    = 1'b0;
      fail_count  = 0;
      byte_count  = 0;
      msg_count   = 0;
      char_count  = 0;
      csr_writes  = 0;
      idle_cycles = 0;
      url_sel     = 1'b0;
      pad_on      = 1'b1;
      group_pos   = PH_0;
      carry       = 4'd0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_encoding();
      test_alphabet_select();
      test_pad_disable();
      test_random_messages();

      $display("covered %0d messages, %0d bytes, %0d chars, %0d register writes",
               msg_count, byte_count, char_count, csr_writes);
      $display("both alphabets, padding on and off, all group end positions, %0d fails",
               fail_count);
      if (fail_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
